FILE: hdl/satlb_pkg.sv
// shared widths and default sizes for the set-associative tlb
`default_nettype none
package satlb_pkg;

  // fixed field widths of the request and response words
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int SET_W   = 4;

  // default geometry
  localparam int LOG_ENTRIES_DEF = 6;
  localparam int LOG_WAYS_DEF    = 2;
  localparam int TAG_BITS_DEF    = 32;
  localparam int DATA_BITS_DEF   = 64;

endpackage
`default_nettype wire

FILE: hdl/satlb_if.sv
// request, response and configuration channel interfaces
`default_nettype none
interface satlb_req_if import satlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               clear_all;
  logic               erase_req;
  logic               write_req;
  logic [VALUE_W-1:0] write_value;
  logic [KEY_W-1:0]   write_key;
  logic [SET_W-1:0]   write_set;
  logic               lookup_req;
  logic [KEY_W-1:0]   lookup_key;
  logic [SET_W-1:0]   lookup_set;

  modport source (
    output valid, clear_all, erase_req, write_req, write_value, write_key, write_set,
    output lookup_req, lookup_key, lookup_set,
    input  ready
  );
  modport sink (
    input  valid, clear_all, erase_req, write_req, write_value, write_key, write_set,
    input  lookup_req, lookup_key, lookup_set,
    output ready
  );
endinterface

interface satlb_rsp_if import satlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [VALUE_W-1:0] hit_value;

  modport source (output valid, hit, hit_value, input ready);
  modport sink (input valid, hit, hit_value, output ready);
endinterface

interface satlb_cfg_if import satlb_pkg::*; ();
  logic valid;
  logic ready;
  logic bypass_disable;

  modport source (output valid, bypass_disable, input ready);
  modport sink (input valid, bypass_disable, output ready);
endinterface
`default_nettype wire

FILE: hdl/satlb_mem.sv
// set row memory: one write port, two registered read ports
`default_nettype none
module satlb_mem import satlb_pkg::*; #(
  parameter int SETS  = 16,
  parameter int SW    = 4,
  parameter int ROW_W = 384
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [SW-1:0]    rd_addr_a,
  input  logic [SW-1:0]    rd_addr_b,
  output logic [ROW_W-1:0] rd_row_a,
  output logic [ROW_W-1:0] rd_row_b,
  input  logic             wr_en,
  input  logic [SW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_row
);

  logic [ROW_W-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_a <= mem[rd_addr_a];
      rd_row_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/satlb_match.sv
// tag compare across the ways of one set row, lowest way wins
`default_nettype none
module satlb_match import satlb_pkg::*; #(
  parameter int NW        = 4,
  parameter int WW        = 2,
  parameter int TAG_BITS  = 32,
  parameter int DATA_BITS = 64
) (
  input  logic [NW-1:0][TAG_BITS+DATA_BITS-1:0] row,
  input  logic [NW-1:0]                         vld,
  input  logic [TAG_BITS-1:0]                   tag,
  output logic                                  hit,
  output logic [WW-1:0]                         way
);

  always_comb begin
    hit = 1'b0;
    way = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (vld[w] && (row[w][DATA_BITS +: TAG_BITS] == tag)) begin
        hit = 1'b1;
        way = WW'(w);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/set_assoc_tlb_round_robin_top.sv
// set-associative tlb with per-set round-robin fill
//
//   channel  dir  handshake      carries
//   req      in   valid/ready    clear/erase/write/lookup request word
//   rsp      out  valid/ready    hit and hit_value
//   cfg      in   valid/ready    bypass_disable (always ready)
//
// per word: the accept edge reads the lookup and write set rows from
// the row memory, the next cycle compares tags, writes the row back and loads the
// output register; no new word is taken until the current one is done.
// reset clears valid bits and bypass_disable and sets fill pointers to the last way at once, no sweep.
// a full, untaken output register holds the word in its compare step.
`default_nettype none
module set_assoc_tlb_round_robin_top import satlb_pkg::*; #(
  parameter int LOG_ENTRIES = LOG_ENTRIES_DEF,
  parameter int LOG_WAYS    = LOG_WAYS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int DATA_BITS   = DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  satlb_req_if.sink   req,
  satlb_rsp_if.source rsp,
  satlb_cfg_if.sink   cfg
);

  localparam int LOG_SETS = (LOG_ENTRIES > LOG_WAYS) ? LOG_ENTRIES - LOG_WAYS : 0;
  localparam int NUM_SETS = 1 << LOG_SETS;
  localparam int NW       = 1 << LOG_WAYS;
  localparam int SW       = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int WW       = (LOG_WAYS > 0) ? LOG_WAYS : 1;
  localparam int EW       = TAG_BITS + DATA_BITS;

  logic                              busy;
  logic                              in_fire;
  logic                              done;
  logic                              bypass_disable;

  logic                              it_clr;
  logic                              it_ers;
  logic                              it_wr;
  logic                              it_lk;
  logic [DATA_BITS-1:0]              it_wdata;
  logic [TAG_BITS-1:0]               it_wtag;
  logic [TAG_BITS-1:0]               it_ltag;
  logic [SW-1:0]                     it_wset;
  logic [SW-1:0]                     it_lset;

  logic [SW-1:0]                     in_wset;
  logic [SW-1:0]                     in_lset;

  logic [NUM_SETS-1:0][NW-1:0]       valid;
  logic [NUM_SETS-1:0][NW-1:0]       valid_next;
  logic [NUM_SETS-1:0][WW-1:0]       last_way;
  logic [NUM_SETS-1:0][WW-1:0]       last_way_next;

  logic [NW-1:0][EW-1:0]             row_l;
  logic [NW-1:0][EW-1:0]             row_w;
  logic [NW-1:0][EW-1:0]             wr_row;
  logic                              mem_we;
  logic [NW-1:0]                     lv;
  logic [NW-1:0]                     wv;
  logic                              hit_l;
  logic                              hit_w;
  logic [WW-1:0]                     way_l;
  logic [WW-1:0]                     way_w;
  logic [WW-1:0]                     fill_way;
  logic                              fwd;

  logic                              out_valid;
  logic                              out_hit;
  logic                              out_hit_next;
  logic [VALUE_W-1:0]                out_value;
  logic [VALUE_W-1:0]                out_value_next;

  assign req.ready = !busy;
  assign in_fire   = req.valid && !busy;
  assign done      = busy && (!out_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.hit_value = out_value;

  // set index keeps its low bits; a single set always lands on row 0
  assign in_wset = (LOG_SETS == 0) ? '0 : SW'(req.write_set);
  assign in_lset = (LOG_SETS == 0) ? '0 : SW'(req.lookup_set);

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_disable <= 1'b0;
    end else if (cfg.valid) begin
      bypass_disable <= cfg.bypass_disable;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_clr   <= req.clear_all;
      it_ers   <= req.erase_req;
      it_wr    <= req.write_req;
      it_lk    <= req.lookup_req;
      it_wdata <= DATA_BITS'(req.write_value);
      it_wtag  <= TAG_BITS'(req.write_key);
      it_ltag  <= TAG_BITS'(req.lookup_key);
      it_wset  <= in_wset;
      it_lset  <= in_lset;
    end
  end

  satlb_mem #(
    .SETS  (NUM_SETS),
    .SW    (SW),
    .ROW_W (NW * EW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr_a (in_lset),
    .rd_addr_b (in_wset),
    .rd_row_a  (row_l),
    .rd_row_b  (row_w),
    .wr_en     (done && mem_we),
    .wr_addr   (it_wset),
    .wr_row    (wr_row)
  );

  // clear in the same word hides every entry from lookup and write
  assign lv = it_clr ? '0 : valid[it_lset];
  assign wv = it_clr ? '0 : valid[it_wset];

  satlb_match #(
    .NW (NW), .WW (WW), .TAG_BITS (TAG_BITS), .DATA_BITS (DATA_BITS)
  ) u_match_l (
    .row (row_l),
    .vld (lv),
    .tag (it_ltag),
    .hit (hit_l),
    .way (way_l)
  );

  satlb_match #(
    .NW (NW), .WW (WW), .TAG_BITS (TAG_BITS), .DATA_BITS (DATA_BITS)
  ) u_match_w (
    .row (row_w),
    .vld (wv),
    .tag (it_wtag),
    .hit (hit_w),
    .way (way_w)
  );

  assign fwd = !bypass_disable && it_wr && !it_ers && (it_lset == it_wset) &&
               (it_ltag == it_wtag);

  always_comb begin
    out_hit_next   = 1'b0;
    out_value_next = '0;
    if (it_lk) begin
      if (fwd) begin
        out_hit_next   = 1'b1;
        out_value_next = VALUE_W'(it_wdata);
      end else if (hit_l) begin
        out_hit_next   = 1'b1;
        out_value_next = VALUE_W'(row_l[way_l][DATA_BITS-1:0]);
      end
    end
  end

  assign fill_way = (last_way[it_wset] + 1'b1) & WW'(NW - 1);

  always_comb begin
    valid_next    = it_clr ? '0 : valid;
    last_way_next = last_way;
    wr_row        = row_w;
    mem_we        = 1'b0;
    if (it_wr || it_ers) begin
      if (hit_w) begin
        if (it_ers) begin
          valid_next[it_wset][way_w] = 1'b0;
        end else begin
          valid_next[it_wset][way_w] = 1'b1;
          wr_row[way_w]              = {it_wtag, it_wdata};
          mem_we                     = 1'b1;
        end
      end else if (!it_ers) begin
        valid_next[it_wset][fill_way] = 1'b1;
        wr_row[fill_way]              = {it_wtag, it_wdata};
        mem_we                        = 1'b1;
        last_way_next[it_wset]        = fill_way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      valid    <= '0;
      last_way <= {NUM_SETS{WW'(NW - 1)}};
    end else begin
      if (in_fire) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        valid    <= valid_next;
        last_way <= last_way_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit   <= out_hit_next;
      out_value <= out_value_next;
    end
  end

  // a word past its accept edge finishes as soon as the output register is free
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && !out_valid |=> out_valid && !busy)
    else $error("word not finished with a free output register");

  // a miss never carries data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.hit_value == '0)
    else $error("miss with nonzero hit_value");

  // after a clear at most the one entry written by the same word is valid
  a_clear: assert property (@(posedge clk) disable iff (rst)
    done && it_clr |=> $countones(valid) <= 1)
    else $error("valid bits left after clear");

endmodule
`default_nettype wire
